// ----- src/lfs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the line-follow steering controller:
// datapath word, sequencer states, register map and fixed limits.
// ---------------------------------------------------------------------------
package lfs_pkg;

    // Datapath word of the shared clamp-add unit (holds +-8191 with margin)
    localparam int WORD_W = 15;
    typedef logic signed [WORD_W-1:0] t_word;

    // Sensor channels
    localparam int NUM_CH   = 6;
    localparam int CH_IDX_W = 3;
    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_BASE_SPEED  = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_CORR_LIMIT  = 3'd2,
        REG_RISE_STEP   = 3'd3,
        REG_FALL_STEP   = 3'd4,
        REG_DEADBAND    = 3'd5,
        REG_STEP_LIMIT  = 3'd6
    } t_reg_idx;

    // Register reset values
    localparam logic [11:0]        BASE_SPEED_RST = 12'd1600;
    localparam logic signed [10:0] GAIN_P_RST     = 11'sd128;
    localparam logic [10:0]        CORR_LIMIT_RST = 11'd720;
    localparam logic [9:0]         RISE_STEP_RST  = 10'd128;
    localparam logic [9:0]         FALL_STEP_RST  = 10'd160;
    localparam logic [2:0]         DEADBAND_RST   = 3'd1;
    localparam logic [3:0]         STEP_LIMIT_RST = 4'd1;

    // Wheel target limits, Q4 rpm (50 and 145 rpm)
    localparam t_word SPEED_MIN = 15'sd800;
    localparam t_word SPEED_MAX = 15'sd2320;

    // Smallest usable slew step
    localparam logic [9:0] STEP_FLOOR = 10'd2;

    // Wide-open clamp bounds
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DEAD,
        S_ESTEP,
        S_EADD,
        S_MUL,
        S_CLAMP,
        S_SLEWSEL,
        S_SLEWD,
        S_SLEWA,
        S_LEFT,
        S_RIGHT,
        S_DONE
    } t_state;

endpackage

// ----- src/lfs_alu.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfs_alu
// Shared clamp-add unit: y = min(max(a + b, lo), hi).
// ---------------------------------------------------------------------------
module lfs_alu (
    input  lfs_pkg::t_word i_a,
    input  lfs_pkg::t_word i_b,
    input  lfs_pkg::t_word i_lo,
    input  lfs_pkg::t_word i_hi,
    output lfs_pkg::t_word o_y
);
    import lfs_pkg::*;

    logic signed [WORD_W:0] sum;
    logic signed [WORD_W:0] lo_x;
    logic signed [WORD_W:0] hi_x;

    // Sum one bit wider so it never wraps
    assign sum  = (WORD_W+1)'(i_a) + (WORD_W+1)'(i_b);
    assign lo_x = (WORD_W+1)'(i_lo);
    assign hi_x = (WORD_W+1)'(i_hi);

    // Clamp to the window
    always_comb begin
        if (sum > hi_x) begin
            o_y = i_hi;
        end else if (sum < lo_x) begin
            o_y = i_lo;
        end else begin
            o_y = sum[WORD_W-1:0];
        end
    end

endmodule

// ----- src/line_follow_steering_controller.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_follow_steering_controller
// P steering controller with slew limit for a 6-channel line sensor.
//
//   Channel  Direction  Handshake                 Carries
//   in       sink       i_in_valid / o_in_ready   sensor bits, line_lost
//   out      source     o_out_valid / i_out_ready error, flags, correction, speeds
//   cfg      sink       APB psel/penable/pready   7 registers at 4*i
//
// A request is scanned one sensor channel per cycle, then goes through the
// deadband, error, gain, clamp, slew and wheel-speed states, most of them
// using the shared clamp-add unit; with line_lost set it goes from deadband
// straight to done. The input is ready again in the cycle the result appears.
// The result sits in an output register, so the next request is taken while
// it waits; the sequencer stalls in its last state only if the previous
// result is still not taken. Reset is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module line_follow_steering_controller #(
    parameter int LOST_CONFIRM = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample request
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [5:0]                  i_sensor_bits,
    input  logic                        i_line_lost,
    // result
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [3:0]           o_track_error,
    output logic                        o_line_seen,
    output logic                        o_lost_locked,
    output logic signed [11:0]          o_correction,
    output logic [11:0]                 o_left_speed,
    output logic [11:0]                 o_right_speed,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [lfs_pkg::DATA_W-1:0]  pwdata,
    output logic [lfs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lfs_pkg::*;

    localparam int RUN_W = $clog2(LOST_CONFIRM + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(LOST_CONFIRM);

    // ---------------- configuration registers ----------------
    logic [11:0]        r_base;
    logic signed [10:0] r_gain;
    logic [10:0]        r_lim;
    logic [9:0]         r_rise;
    logic [9:0]         r_fall;
    logic [2:0]         r_db;
    logic [3:0]         r_step_lim;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_SPEED_RST;
            r_gain     <= GAIN_P_RST;
            r_lim      <= CORR_LIMIT_RST;
            r_rise     <= RISE_STEP_RST;
            r_fall     <= FALL_STEP_RST;
            r_db       <= DEADBAND_RST;
            r_step_lim <= STEP_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BASE_SPEED: r_base     <= pwdata[11:0];
                REG_GAIN_P:     r_gain     <= signed'(pwdata[10:0]);
                REG_CORR_LIMIT: r_lim      <= pwdata[10:0];
                REG_RISE_STEP:  r_rise     <= pwdata[9:0];
                REG_FALL_STEP:  r_fall     <= pwdata[9:0];
                REG_DEADBAND:   r_db       <= pwdata[2:0];
                REG_STEP_LIMIT: r_step_lim <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (cfg_idx)
            REG_BASE_SPEED: prdata = DATA_W'(r_base);
            REG_GAIN_P:     prdata = DATA_W'(unsigned'(r_gain));
            REG_CORR_LIMIT: prdata = DATA_W'(r_lim);
            REG_RISE_STEP:  prdata = DATA_W'(r_rise);
            REG_FALL_STEP:  prdata = DATA_W'(r_fall);
            REG_DEADBAND:   prdata = DATA_W'(r_db);
            REG_STEP_LIMIT: prdata = DATA_W'(r_step_lim);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    t_state r_state, n_state;

    // scan registers
    logic [5:0]          r_mask;
    logic                r_lost;
    logic [CH_IDX_W-1:0] r_idx;
    logic [CH_IDX_W-1:0] r_run_start;
    logic [CH_IDX_W-1:0] r_run_len;
    logic signed [3:0]   r_best;
    logic [3:0]          r_best_dist;
    logic [CH_IDX_W-1:0] r_best_len;

    // control state
    logic signed [3:0]   r_prev_err;
    logic signed [11:0]  r_corr;
    logic [RUN_W-1:0]    r_lost_run;
    logic                r_lost_cfm;
    logic [11:0]         r_left;
    logic [11:0]         r_right;

    // working registers
    logic signed [3:0]   r_meas;
    logic signed [3:0]   r_e;
    t_word               r_acc;
    logic signed [11:0]  r_tgt;
    logic [9:0]          r_step;

    // output register
    logic                r_out_valid;
    logic signed [3:0]   r_o_err;
    logic                r_o_seen;
    logic                r_o_cfm;
    logic signed [11:0]  r_o_corr;
    logic [11:0]         r_o_left;
    logic [11:0]         r_o_right;

    logic in_acc;
    logic out_load;

    // ---------------- scan step: one channel per cycle ----------------
    logic [CH_IDX_W-1:0] len_n;
    logic [CH_IDX_W-1:0] start_n;
    logic                run_end;
    logic signed [5:0]   cand;
    logic signed [5:0]   diff;
    logic [3:0]          cand_dist;
    logic                better;

    always_comb begin
        len_n     = r_mask[0] ? r_run_len + 1'b1 : '0;
        start_n   = (r_mask[0] && (r_run_len == '0)) ? r_idx : r_run_start;
        run_end   = r_mask[0] && !r_mask[1];
        // run center, doubled and taken from the array center: 2*start + len - 6
        cand      = signed'({2'b00, start_n, 1'b0}) + signed'({3'b000, len_n}) - 6'sd6;
        diff      = cand - 6'(r_prev_err);
        cand_dist = diff[5] ? 4'(-diff) : diff[3:0];
        better    = run_end && ((cand_dist < r_best_dist) ||
                                ((cand_dist == r_best_dist) && (len_n > r_best_len)));
    end

    // ---------------- deadband and lost counting ----------------
    logic [3:0]       best_abs;
    logic [RUN_W-1:0] lost_run_n;

    assign best_abs   = r_best[3] ? 4'(-r_best) : r_best;
    assign lost_run_n = (r_lost_run < RUN_MAX) ? r_lost_run + 1'b1 : r_lost_run;

    // ---------------- slew step choice ----------------
    logic [11:0] tgt_abs;
    logic [11:0] corr_abs;
    logic [9:0]  step_raw;

    assign tgt_abs  = r_tgt[11] ? 12'(-r_tgt) : r_tgt;
    assign corr_abs = r_corr[11] ? 12'(-r_corr) : r_corr;
    assign step_raw = (tgt_abs > corr_abs) ? r_rise : r_fall;

    // ---------------- limit write clamps held correction ----------------
    logic signed [11:0] new_lim;
    logic signed [11:0] corr_cfg;

    assign new_lim = signed'({1'b0, pwdata[10:0]});
    always_comb begin
        if (r_corr > new_lim) begin
            corr_cfg = new_lim;
        end else if (r_corr < -new_lim) begin
            corr_cfg = -new_lim;
        end else begin
            corr_cfg = r_corr;
        end
    end

    // ---------------- shared clamp-add unit ----------------
    t_word alu_a, alu_b, alu_lo, alu_hi, alu_y;
    t_word lim_w;

    assign lim_w = t_word'(r_lim);

    lfs_alu u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_lo (alu_lo),
        .i_hi (alu_hi),
        .o_y  (alu_y)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_SCAN;
            S_SCAN:    if (r_idx == LAST_CH) n_state = S_DEAD;
            S_DEAD:    n_state = r_lost ? S_DONE : S_ESTEP;
            S_ESTEP:   n_state = S_EADD;
            S_EADD:    n_state = S_MUL;
            S_MUL:     n_state = S_CLAMP;
            S_CLAMP:   n_state = S_SLEWSEL;
            S_SLEWSEL: n_state = S_SLEWD;
            S_SLEWD:   n_state = S_SLEWA;
            S_SLEWA:   n_state = S_LEFT;
            S_LEFT:    n_state = S_RIGHT;
            S_RIGHT:   n_state = S_DONE;
            S_DONE:    if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs: handshake and operand select ----------------
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        alu_a      = '0;
        alu_b      = '0;
        alu_lo     = WORD_MIN;
        alu_hi     = WORD_MAX;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_ESTEP: begin
                // delta = meas - prev, limited to +-step_limit
                alu_a  = t_word'(r_meas);
                alu_b  = -t_word'(r_prev_err);
                alu_lo = -t_word'(r_step_lim);
                alu_hi = t_word'(r_step_lim);
            end
            S_EADD: begin
                alu_a = t_word'(r_prev_err);
                alu_b = r_acc;
            end
            S_CLAMP: begin
                alu_a  = r_acc;
                alu_lo = -lim_w;
                alu_hi = lim_w;
            end
            S_SLEWD: begin
                alu_a  = t_word'(r_tgt);
                alu_b  = -t_word'(r_corr);
                alu_lo = -t_word'(r_step);
                alu_hi = t_word'(r_step);
            end
            S_SLEWA: begin
                alu_a  = t_word'(r_corr);
                alu_b  = r_acc;
                alu_lo = -lim_w;
                alu_hi = lim_w;
            end
            S_LEFT: begin
                alu_a  = t_word'(r_base);
                alu_b  = t_word'(r_corr);
                alu_lo = SPEED_MIN;
                alu_hi = SPEED_MAX;
            end
            S_RIGHT: begin
                alu_a  = t_word'(r_base);
                alu_b  = -t_word'(r_corr);
                alu_lo = SPEED_MIN;
                alu_hi = SPEED_MAX;
            end
            S_DONE: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_err  <= '0;
            r_corr      <= '0;
            r_lost_run  <= '0;
            r_lost_cfm  <= 1'b0;
            r_left      <= BASE_SPEED_RST;
            r_right     <= BASE_SPEED_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_DEAD) begin
                if (r_lost) begin
                    r_lost_run <= lost_run_n;
                    if (lost_run_n == RUN_MAX) r_lost_cfm <= 1'b1;
                end else begin
                    r_lost_run <= '0;
                    r_lost_cfm <= 1'b0;
                end
            end

            // correction: limit write clamps, sequencer otherwise
            if (cfg_wr && (cfg_idx == REG_CORR_LIMIT)) begin
                r_corr <= corr_cfg;
            end else if (r_state == S_SLEWA) begin
                r_corr     <= alu_y[11:0];
                r_prev_err <= r_e;
            end

            if (r_state == S_LEFT)  r_left  <= alu_y[11:0];
            if (r_state == S_RIGHT) r_right <= alu_y[11:0];
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mask      <= i_sensor_bits;
            r_lost      <= i_line_lost;
            r_idx       <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_best      <= r_prev_err;
            r_best_dist <= '1;
            r_best_len  <= '0;
        end

        case (r_state)
            S_SCAN: begin
                r_mask      <= r_mask >> 1;
                r_idx       <= r_idx + 1'b1;
                r_run_len   <= len_n;
                r_run_start <= start_n;
                if (better) begin
                    r_best      <= cand[3:0];
                    r_best_dist <= cand_dist;
                    r_best_len  <= len_n;
                end
            end
            S_DEAD:    r_meas <= (best_abs <= {1'b0, r_db}) ? '0 : r_best;
            S_ESTEP:   r_acc  <= alu_y;
            S_EADD:    r_e    <= alu_y[3:0];
            S_MUL:     r_acc  <= t_word'(r_gain) * t_word'(r_e);
            S_CLAMP:   r_tgt  <= alu_y[11:0];
            S_SLEWSEL: r_step <= (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;
            S_SLEWD:   r_acc  <= alu_y;
            default: ;
        endcase

        if (out_load) begin
            r_o_err   <= r_prev_err;
            r_o_seen  <= !r_lost;
            r_o_cfm   <= r_lost_cfm;
            r_o_corr  <= r_corr;
            r_o_left  <= r_left;
            r_o_right <= r_right;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_track_error    = r_o_err;
    assign o_line_seen      = r_o_seen;
    assign o_lost_locked    = r_o_cfm;
    assign o_correction     = r_o_corr;
    assign o_left_speed     = r_o_left;
    assign o_right_speed    = r_o_right;

endmodule
